### rtl/core/hac_pkg.sv
// shared types and constants of the hashed address cache
package hac_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DAY_W   = 9;
    localparam int unsigned ENTRY_W = ADDR_W + VALUE_W + DAY_W;

    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;

    localparam logic [DAY_W-1:0] EXPIRE_RESET = 9'd2;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  tag;
        logic [VALUE_W-1:0] value;
        logic [DAY_W-1:0]   day;
    } entry_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hash;
    } hash_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_RESOLVE
    } state_t;

endpackage

### rtl/core/hac_ram.sv
// generic simple dual-port ram with registered read
module hac_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/hac_hash.sv
// iterative fnv-1 hash over the four address bytes, one byte per cycle
module hac_hash (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       key,
    output hac_pkg::hash_rsp_t rsp
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] key_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] prod;

    assign prod     = acc_reg * hac_pkg::FNV_PRIME;
    assign acc_next = prod ^ {24'd0, key_reg[{step_reg, 3'b000} +: 8]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= hac_pkg::FNV_BASIS;
            key_reg <= key;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hash = acc_reg;

endmodule

### rtl/core/hashed_address_cache_with_expiry.sv
// top level of the direct-mapped address cache with day-based expiry
//
// Direct-mapped cache of 2^INDEX_BITS entries, indexed by the low bits of a
// 32-bit FNV-1 hash of the address. After reset the block runs a clearing
// pass over all 2^INDEX_BITS entries, one entry per cycle, with s_tready
// low; configuration writes are taken throughout. One item is in work at a
// time: it is accepted, takes four hash steps through the shared constant
// multiplier, after which the done flag is registered, is read from memory
// and is then compared and, for an insert, written back, with the result
// loaded into the output register. The next item is accepted the cycle after
// that while the result waits in the output register; a result not taken
// before the following one is ready holds that item in its final cycle.
module hashed_address_cache_with_expiry #(
    parameter int unsigned INDEX_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,   // expire_days
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // address, entry_value, current_day, zero pad
    input  logic [0:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // found_value
    output logic [0:0]  m_tuser     // hit
);

    localparam int unsigned DEPTH = 1 << INDEX_BITS;

    hac_pkg::state_t    state_reg;
    hac_pkg::state_t    state_next;
    hac_pkg::hash_rsp_t hash_rsp;
    hac_pkg::entry_t    rd_entry;
    hac_pkg::entry_t    wr_entry;

    logic [INDEX_BITS-1:0]     clr_idx_reg;
    logic [INDEX_BITS-1:0]     index;
    logic [hac_pkg::DAY_W-1:0] expire_reg;
    logic                      req_type_reg;
    logic [31:0]               addr_reg;
    logic [31:0]               value_reg;
    logic [8:0]                day_reg;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [31:0]               found_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic [31:0]               found_next;

    logic accept;
    logic hash_start;
    logic out_free;
    logic load_out;
    logic ram_we;
    logic ram_re;
    logic [INDEX_BITS-1:0]          ram_waddr;
    logic [hac_pkg::ENTRY_W-1:0]    ram_rdata;
    logic [hac_pkg::DAY_W:0]        expire_sum;
    logic                           unexpired;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign index     = hash_rsp.hash[INDEX_BITS-1:0];

    hac_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (s_tdata[31:0]),
        .rsp   (hash_rsp)
    );

    hac_ram #(
        .WIDTH (hac_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (index),
        .rdata (ram_rdata)
    );

    assign rd_entry = hac_pkg::entry_t'(ram_rdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hac_pkg::ST_CLEAR:
            begin
                if (&clr_idx_reg)
                begin
                    state_next = hac_pkg::ST_IDLE;
                end
            end
            hac_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = hac_pkg::ST_HASH;
                end
            end
            hac_pkg::ST_HASH:
            begin
                if (hash_rsp.done)
                begin
                    state_next = hac_pkg::ST_READ;
                end
            end
            hac_pkg::ST_READ:
            begin
                state_next = hac_pkg::ST_RESOLVE;
            end
            hac_pkg::ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = hac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hac_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        hash_start = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = index;
        load_out   = 1'b0;
        wr_entry   = '{tag: addr_reg, value: value_reg, day: day_reg};
        case (state_reg)
            hac_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                wr_entry  = '0;
            end
            hac_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                hash_start = s_tvalid;
            end
            hac_pkg::ST_HASH:
            begin
            end
            hac_pkg::ST_READ:
            begin
                ram_re = 1'b1;
            end
            hac_pkg::ST_RESOLVE:
            begin
                load_out = out_free;
                ram_we   = out_free && (req_type_reg == hac_pkg::REQ_INSERT);
            end
            default:
            begin
            end
        endcase
    end

    assign expire_sum = {1'b0, rd_entry.day} + {1'b0, expire_reg};
    assign unexpired  = expire_sum > {1'b0, day_reg};

    always_comb
    begin
        hit_next   = (req_type_reg == hac_pkg::REQ_LOOKUP) && (addr_reg != 32'd0)
                     && (rd_entry.tag == addr_reg) && unexpired;
        found_next = hit_next ? rd_entry.value : 32'd0;
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hac_pkg::ST_CLEAR;
            clr_idx_reg  <= '0;
            expire_reg   <= hac_pkg::EXPIRE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == hac_pkg::ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                expire_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= s_tuser[0];
            addr_reg     <= s_tdata[31:0];
            value_reg    <= s_tdata[63:32];
            day_reg      <= s_tdata[72:64];
        end
        if (load_out)
        begin
            hit_reg   <= hit_next;
            found_reg <= found_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = found_reg;
    assign m_tuser[0] = hit_reg;

`ifndef SYNTH
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == hac_pkg::ST_CLEAR)
                   || (state_reg == hac_pkg::ST_RESOLVE && req_type_reg == hac_pkg::REQ_INSERT))
        else $error("table written outside clear or insert");

    a_hit_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && hit_next) |-> (rd_entry.tag == addr_reg) && (addr_reg != 32'd0))
        else $error("hit without matching tag");

    a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
        hash_rsp.done |-> (state_reg == hac_pkg::ST_HASH))
        else $error("hash finished outside hash state");

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == hac_pkg::ST_HASH))
        else $error("accepted item did not start hashing");
`endif

endmodule

### tb/sv/hashed_address_cache_with_expiry_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the hashed address cache: directed table, then random traffic
module hashed_address_cache_with_expiry_tb;

    localparam int unsigned INDEX_BITS      = 12;
    localparam int unsigned DEPTH           = 1 << INDEX_BITS;
    localparam int          DIR_ROWS        = 22;
    localparam int          PHASES          = 5;
    localparam int          ITEMS_PER_PHASE = 80;
    localparam int          POOL_SIZE       = 16;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          TAIL_CYCLES     = 20;
    localparam int          QUIET_LIMIT     = 20000;

    typedef logic [hac_pkg::DAY_W-1:0] day_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] value;
    } cache_result_t;

    typedef struct packed {
        logic                        req;
        logic [hac_pkg::ADDR_W-1:0]  addr;
        logic [hac_pkg::VALUE_W-1:0] val;
        logic [hac_pkg::DAY_W-1:0]   day;
        logic                        typed;
        logic                        exp_hit;
        logic [hac_pkg::VALUE_W-1:0] exp_val;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // address, entry_value, current_day, zero pad
    logic [0:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // found_value
    logic [0:0]  m_tuser;   // hit

    logic [hac_pkg::ADDR_W-1:0]  tag_mem   [DEPTH];
    logic [hac_pkg::VALUE_W-1:0] value_mem [DEPTH];
    logic [hac_pkg::DAY_W-1:0]   day_mem   [DEPTH];
    logic [hac_pkg::DAY_W-1:0]   expire_days;

    cache_result_t pending_results [$];
    dir_row_t      directed_rows [DIR_ROWS];
    int            mismatch_count;
    int            quiet_cycles;
    bit            no_idle;
    bit            hold_off_request;

    hashed_address_cache_with_expiry #(
        .INDEX_BITS(INDEX_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [INDEX_BITS-1:0] cache_slot(input logic [hac_pkg::ADDR_W-1:0] addr);
        logic [31:0] h;
        h = hac_pkg::FNV_BASIS;
        for (int b = 0; b < 4; b++)
        begin
            h = h * hac_pkg::FNV_PRIME;
            h = h ^ {24'd0, addr[8*b +: 8]};
        end
        return h[INDEX_BITS-1:0];
    endfunction

    function automatic cache_result_t cache_access(input logic req,
                                                   input logic [hac_pkg::ADDR_W-1:0] addr,
                                                   input logic [hac_pkg::VALUE_W-1:0] val,
                                                   input logic [hac_pkg::DAY_W-1:0] day);
        logic [INDEX_BITS-1:0] slot;
        cache_result_t         res;
        slot      = cache_slot(addr);
        res.hit   = 1'b0;
        res.value = '0;
        if (req == hac_pkg::REQ_INSERT)
        begin
            tag_mem[slot]   = addr;
            value_mem[slot] = val;
            day_mem[slot]   = day;
        end
        else if (addr != '0 && tag_mem[slot] == addr &&
                 ({1'b0, day_mem[slot]} + {1'b0, expire_days}) > {1'b0, day})
        begin
            res.hit   = 1'b1;
            res.value = value_mem[slot];
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // drive one item at the falling edge and log its expectation once accepted
    task automatic send_request(input logic req, input logic [hac_pkg::ADDR_W-1:0] addr,
                                input logic [hac_pkg::VALUE_W-1:0] val,
                                input logic [hac_pkg::DAY_W-1:0] day,
                                input logic typed, input logic exp_hit,
                                input logic [hac_pkg::VALUE_W-1:0] exp_val);
        int            gap;
        cache_result_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, day, val, addr};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        want = cache_access(req, addr, val, day);
        if (typed)
        begin
            want.hit   = exp_hit;
            want.value = exp_val;
        end
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_expire(input logic [hac_pkg::DAY_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        expire_days = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", {31'd0, m_tuser[0]}, {31'd0, want.hit});
                if (m_tdata !== want.value)
                    report_mismatch("found_value", m_tdata, want.value);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random ready gaps and one long hold-off
    initial
    begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = hold_off_request ? HOLD_OFF_CYCLES : pick_gap();
            hold_off_request = 1'b0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [hac_pkg::ADDR_W-1:0]  pool [POOL_SIZE];
        logic [hac_pkg::ADDR_W-1:0]  addr;
        logic [hac_pkg::VALUE_W-1:0] val;
        logic [hac_pkg::DAY_W-1:0]   today;
        logic [hac_pkg::DAY_W-1:0]   day;
        logic                        req;
        int                          r;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = '0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        no_idle          = 1'b0;
        hold_off_request = 1'b0;
        expire_days      = hac_pkg::EXPIRE_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_mem[i]   = '0;
            value_mem[i] = '0;
            day_mem[i]   = '0;
        end

        directed_rows = '{
            '{hac_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 9'd0,   1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd365, 1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd365, 1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 9'd365, 1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 9'd366, 1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 9'd367, 1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_INSERT, 32'h0000_0000, 32'h1234_5678, 9'd0,   1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 9'd0,   1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0000, 9'd0,   1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF, 9'd0,   1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 9'd1,   1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 9'd2,   1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 9'd511, 1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 9'd511, 1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 9'd0,   1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_INSERT, 32'h1234_5678, 32'hDEAD_BEEF, 9'd100, 1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h1234_5679, 32'h0000_0000, 9'd100, 1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000, 9'd101, 1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_INSERT, 32'h1234_5678, 32'h5A5A_5A5A, 9'd1,   1'b1, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000, 9'd2,   1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000, 9'd3,   1'b0, 1'b0, 32'h0},
            '{hac_pkg::REQ_LOOKUP, 32'h0000_0002, 32'h0000_0000, 9'd0,   1'b0, 1'b0, 32'h0}
        };

        // address pool in colliding pairs, zero address among them
        for (int k = 0; k < POOL_SIZE / 2; k++)
        begin
            pool[2*k] = (k == 0) ? 32'h0 : $urandom;
            do addr = $urandom;
            while (addr == pool[2*k] || cache_slot(addr) != cache_slot(pool[2*k]));
            pool[2*k+1] = addr;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(directed_rows[i].req, directed_rows[i].addr, directed_rows[i].val,
                         directed_rows[i].day, directed_rows[i].typed,
                         directed_rows[i].exp_hit, directed_rows[i].exp_val);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: write_expire(9'd0);
                1: write_expire(9'd365);
                2: write_expire(9'd511);
                3: write_expire(9'd1);
                default: write_expire(day_t'($urandom_range(0, 511)));
            endcase
            no_idle = (phase == 3);
            if (phase == 1)
                hold_off_request = 1'b1;
            today = day_t'($urandom_range(0, 365));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    req  = hac_pkg::REQ_INSERT;
                    addr = pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                else if (r < 90)
                begin
                    req  = hac_pkg::REQ_LOOKUP;
                    addr = pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                else
                begin
                    req  = (r < 95) ? hac_pkg::REQ_LOOKUP : hac_pkg::REQ_INSERT;
                    addr = $urandom;
                end
                val = $urandom;
                if ($urandom_range(0, 9) == 0)
                    today = today + day_t'($urandom_range(1, 3));
                r = $urandom_range(0, 99);
                if (r < 70)
                    day = today;
                else if (r < 85)
                    day = today + day_t'($urandom_range(0, expire_days + 1));
                else if (r < 95)
                    day = today - day_t'($urandom_range(0, 2));
                else
                    day = day_t'($urandom_range(0, 511));
                send_request(req, addr, val, day, 1'b0, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
